FILE: rtl/laser_scan_landmark_clusterer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the landmark clusterer
// Clocked on i_clk and switched off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LASER_SCAN_LANDMARK_CLUSTERER_MACROS_SVH
`define LASER_SCAN_LANDMARK_CLUSTERER_MACROS_SVH

// Same-cycle implication.
`define LSLC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LSLC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lslc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslc_pkg
// Shared types, constants and helper functions of the landmark clusterer.
// ----------------------------------------------------------------------------
package lslc_pkg;

    // Default sizes.
    localparam int MAX_BEAMS_DEF   = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration register indexes.
    localparam logic [2:0] REG_RANGE_MIN   = 3'd0;
    localparam logic [2:0] REG_RANGE_MAX   = 3'd1;
    localparam logic [2:0] REG_ANGLE_START = 3'd2;
    localparam logic [2:0] REG_ANGLE_STEP  = 3'd3;
    localparam logic [2:0] REG_MOUNT_COS   = 3'd4;
    localparam logic [2:0] REG_MOUNT_SIN   = 3'd5;
    localparam logic [2:0] REG_MOUNT_X     = 3'd6;
    localparam logic [2:0] REG_MOUNT_Y     = 3'd7;

    // Fixed-point constants (2^24 per turn inside the CORDIC units).
    localparam logic signed [25:0] QUARTER_T = 26'sd4194304;
    localparam logic signed [25:0] HALF_T    = 26'sd8388608;
    localparam logic signed [23:0] INV_GAIN  = 24'sd39797;
    localparam logic signed [47:0] JOIN_D2   = 48'sd167773;
    localparam logic signed [45:0] PUSH_MAG  = 46'sd52429;
    localparam logic [20:0]        MIN_PAD   = 21'd20;
    localparam logic [10:0]        COUNT_FULL = 11'd2047;

    typedef struct packed {
        logic        [19:0] min_range;
        logic        [19:0] max_range;
        logic signed [15:0] angle_start;
        logic signed [15:0] angle_step;
        logic signed [15:0] mount_cos;
        logic signed [15:0] mount_sin;
        logic signed [21:0] mount_x;
        logic signed [21:0] mount_y;
    } t_cfg;

    // One closed cluster handed from the front to the back.
    typedef struct packed {
        logic [31:0] sum_x;
        logic [31:0] sum_y;
        logic [10:0] count;
        logic        last;
    } t_job;

    // CORDIC angle table, 2^24 per turn.
    function automatic logic signed [25:0] atan_lut(input logic [3:0] i);
        logic signed [25:0] v;
        case (i)
            4'd0:    v = 26'sd2097152;
            4'd1:    v = 26'sd1238021;
            4'd2:    v = 26'sd654136;
            4'd3:    v = 26'sd332050;
            4'd4:    v = 26'sd166669;
            4'd5:    v = 26'sd83416;
            4'd6:    v = 26'sd41718;
            4'd7:    v = 26'sd20860;
            4'd8:    v = 26'sd10430;
            4'd9:    v = 26'sd5215;
            4'd10:   v = 26'sd2608;
            4'd11:   v = 26'sd1304;
            4'd12:   v = 26'sd652;
            4'd13:   v = 26'sd326;
            4'd14:   v = 26'sd163;
            default: v = 26'sd81;
        endcase
        return v;
    endfunction

    // Saturate to the signed 22-bit coordinate range.
    function automatic logic signed [21:0] sat22(input logic signed [47:0] v);
        logic signed [21:0] r;
        if (v > 48'sd2097151) begin
            r = 22'sd2097151;
        end else if (v < -48'sd2097152) begin
            r = -22'sd2097152;
        end else begin
            r = v[21:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/lslc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslc interfaces
// Beam input, landmark output and configuration write channels.
// ----------------------------------------------------------------------------
interface lslc_beam_if;
    logic        valid;
    logic        ready;
    logic [19:0] beam_range;
    logic        beam_no_return;
    logic        last_beam;
    modport source (output valid, beam_range, beam_no_return, last_beam, input ready);
    modport sink   (input valid, beam_range, beam_no_return, last_beam, output ready);
endinterface

interface lslc_lmk_if;
    logic               valid;
    logic               ready;
    logic        [21:0] landmark_range;
    logic signed [15:0] landmark_bearing;
    logic signed [21:0] landmark_x;
    logic signed [21:0] landmark_y;
    logic               scan_last;
    modport source (output valid, landmark_range, landmark_bearing, landmark_x,
                    landmark_y, scan_last, input ready);
    modport sink   (input valid, landmark_range, landmark_bearing, landmark_x,
                    landmark_y, scan_last, output ready);
endinterface

interface lslc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [21:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/lslc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslc_queue
// Small FIFO of closed clusters between the beam front and the landmark back.
// ----------------------------------------------------------------------------
module lslc_queue import lslc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);
    localparam int AW = $clog2(DEPTH);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

FILE: rtl/lslc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslc_front
// Takes beams, turns kept ones into robot-frame points and grows clusters.
// ----------------------------------------------------------------------------
`include "laser_scan_landmark_clusterer_macros.svh"

module lslc_front import lslc_pkg::*; #(
    parameter int MAX_BEAMS = MAX_BEAMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lslc_beam_if.sink   i_beam,
    input  t_cfg        i_cfg,
    output t_job        o_job,
    output logic        o_job_valid,
    input  logic        i_job_full
);
    localparam int IW = $clog2(MAX_BEAMS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ANG  = 4'd1;
    localparam logic [3:0] S_PRE  = 4'd2;
    localparam logic [3:0] S_ROT  = 4'd3;
    localparam logic [3:0] S_GX   = 4'd4;
    localparam logic [3:0] S_GY   = 4'd5;
    localparam logic [3:0] S_M0   = 4'd6;
    localparam logic [3:0] S_M1   = 4'd7;
    localparam logic [3:0] S_M2   = 4'd8;
    localparam logic [3:0] S_M3   = 4'd9;
    localparam logic [3:0] S_M4   = 4'd10;
    localparam logic [3:0] S_D0   = 4'd11;
    localparam logic [3:0] S_D1   = 4'd12;
    localparam logic [3:0] S_DEC  = 4'd13;
    localparam logic [3:0] S_FIN  = 4'd14;

    logic [3:0]         r_state;
    logic [IW-1:0]      r_idx;
    logic               r_last;
    logic [19:0]        r_rng;
    logic [15:0]        r_ang;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [25:0] r_z;
    logic [3:0]         r_it;
    logic signed [23:0] r_lx;
    logic signed [23:0] r_ly;
    logic signed [47:0] r_acc;
    logic signed [21:0] r_px;
    logic signed [21:0] r_py;
    logic               r_open;
    logic [31:0]        r_sx;
    logic [31:0]        r_sy;
    logic [10:0]        r_cnt;
    logic signed [21:0] r_prevx;
    logic signed [21:0] r_prevy;

    logic signed [23:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [56:0] mul_p;
    logic signed [56:0] rnd24;
    logic signed [23:0] dxw;
    logic signed [23:0] dyw;
    logic signed [25:0] z0;
    logic signed [31:0] mag;
    logic signed [31:0] x_sh;
    logic signed [31:0] y_sh;
    logic signed [25:0] tab;
    logic               keep;
    logic               brk;

    // Rounds acc >> 14, adds the offset and clamps to the coordinate range.
    function automatic logic signed [21:0] mount_fix(input logic signed [47:0] acc,
                                                     input logic signed [21:0] off);
        logic signed [47:0] t;
        t = ((acc + 48'sd8192) >>> 14) + 48'(off);
        return sat22(t);
    endfunction

    assign i_beam.ready = (r_state == S_IDLE);

    assign keep = !i_beam.beam_no_return
               && ({1'b0, i_beam.beam_range} >= ({1'b0, i_cfg.min_range} + MIN_PAD))
               && (i_beam.beam_range <= i_cfg.max_range);

    assign dxw   = 24'(r_px) - 24'(r_prevx);
    assign dyw   = 24'(r_py) - 24'(r_prevy);
    assign z0    = {{2{r_ang[15]}}, r_ang, 8'd0};
    assign mag   = {4'd0, r_rng, 8'd0};
    assign x_sh  = r_x >>> r_it;
    assign y_sh  = r_y >>> r_it;
    assign tab   = atan_lut(r_it);
    assign brk   = r_open && (r_acc >= JOIN_D2);
    assign rnd24 = mul_p + (57'sd1 <<< 23);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_ANG: begin
                mul_a = 24'(i_cfg.angle_step);
                mul_b = 33'(r_idx);
            end
            S_GX: begin
                mul_a = INV_GAIN;
                mul_b = 33'(r_x);
            end
            S_GY: begin
                mul_a = INV_GAIN;
                mul_b = 33'(r_y);
            end
            S_M0: begin
                mul_a = r_lx;
                mul_b = 33'(i_cfg.mount_cos);
            end
            S_M1: begin
                mul_a = r_ly;
                mul_b = 33'(i_cfg.mount_sin);
            end
            S_M2: begin
                mul_a = r_lx;
                mul_b = 33'(i_cfg.mount_sin);
            end
            S_M3: begin
                mul_a = r_ly;
                mul_b = 33'(i_cfg.mount_cos);
            end
            S_D0: begin
                mul_a = dxw;
                mul_b = 33'(dxw);
            end
            S_D1: begin
                mul_a = dyw;
                mul_b = 33'(dyw);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Cluster closes go out to the queue.
    assign o_job_valid = !i_job_full
                      && (((r_state == S_DEC) && brk)
                       || ((r_state == S_FIN) && r_last && r_open));
    assign o_job = '{sum_x: r_sx, sum_y: r_sy, count: r_cnt, last: (r_state == S_FIN)};

    // Beam sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_open  <= 1'b0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_beam.valid) begin
                        r_rng   <= i_beam.beam_range;
                        r_last  <= i_beam.last_beam || (r_idx == IW'(MAX_BEAMS - 1));
                        r_state <= keep ? S_ANG : S_FIN;
                    end
                end
                S_ANG: begin
                    r_ang   <= i_cfg.angle_start + mul_p[15:0];
                    r_state <= S_PRE;
                end
                S_PRE: begin
                    // Fold the angle into the right half-plane.
                    r_y  <= '0;
                    r_it <= '0;
                    if (z0 > QUARTER_T) begin
                        r_x <= -mag;
                        r_z <= z0 - HALF_T;
                    end else if (z0 < -QUARTER_T) begin
                        r_x <= -mag;
                        r_z <= z0 + HALF_T;
                    end else begin
                        r_x <= mag;
                        r_z <= z0;
                    end
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (!r_z[25]) begin
                        r_x <= r_x - y_sh;
                        r_y <= r_y + x_sh;
                        r_z <= r_z - tab;
                    end else begin
                        r_x <= r_x + y_sh;
                        r_y <= r_y - x_sh;
                        r_z <= r_z + tab;
                    end
                    r_it <= r_it + 1'b1;
                    if (r_it == 4'd15) begin
                        r_state <= S_GX;
                    end
                end
                S_GX: begin
                    r_lx    <= rnd24[47:24];
                    r_state <= S_GY;
                end
                S_GY: begin
                    r_ly    <= rnd24[47:24];
                    r_state <= S_M0;
                end
                S_M0: begin
                    r_acc   <= mul_p[47:0];
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_acc   <= r_acc - mul_p[47:0];
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_px    <= mount_fix(r_acc, i_cfg.mount_x);
                    r_acc   <= mul_p[47:0];
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_acc   <= r_acc + mul_p[47:0];
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_py    <= mount_fix(r_acc, i_cfg.mount_y);
                    r_state <= r_open ? S_D0 : S_DEC;
                end
                S_D0: begin
                    r_acc   <= mul_p[47:0];
                    r_state <= S_D1;
                end
                S_D1: begin
                    r_acc   <= r_acc + mul_p[47:0];
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    // A break waits for room in the queue.
                    if (!(brk && i_job_full)) begin
                        if (brk || !r_open) begin
                            r_open <= 1'b1;
                            r_sx   <= 32'(r_px);
                            r_sy   <= 32'(r_py);
                            r_cnt  <= 11'd1;
                        end else if (r_cnt < COUNT_FULL) begin
                            r_sx  <= r_sx + 32'(r_px);
                            r_sy  <= r_sy + 32'(r_py);
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_prevx <= r_px;
                        r_prevy <= r_py;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_last) begin
                        if (!(r_open && i_job_full)) begin
                            r_open  <= 1'b0;
                            r_sx    <= '0;
                            r_sy    <= '0;
                            r_cnt   <= '0;
                            r_idx   <= '0;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks on the front sequencer.
    `LSLC_ASSERT_NOW(a_push_room, o_job_valid, !i_job_full, "push into a full queue")
    `LSLC_ASSERT_NXT(a_busy_after_take, i_beam.valid && i_beam.ready, !i_beam.ready,
                     "front ready right after taking a beam")
    `LSLC_ASSERT_NOW(a_idx_bound, r_state == S_IDLE, r_idx <= IW'(MAX_BEAMS - 1),
                     "beam index past the scan limit")
    `LSLC_ASSERT_NOW(a_open_count, r_open, r_cnt != '0, "open cluster with zero count")
endmodule

FILE: rtl/lslc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslc_back
// Turns a closed cluster into a landmark: mean, bearing, push-out and range.
// ----------------------------------------------------------------------------
module lslc_back import lslc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_job_empty,
    output logic        o_job_pop,
    lslc_lmk_if.source  o_landmark
);
    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_DIV  = 4'd1;
    localparam logic [3:0] B_MEAN = 4'd2;
    localparam logic [3:0] B_VPRE = 4'd3;
    localparam logic [3:0] B_VEC  = 4'd4;
    localparam logic [3:0] B_BEAR = 4'd5;
    localparam logic [3:0] B_RPRE = 4'd6;
    localparam logic [3:0] B_ROT  = 4'd7;
    localparam logic [3:0] B_GX   = 4'd8;
    localparam logic [3:0] B_GY   = 4'd9;
    localparam logic [3:0] B_LXY  = 4'd10;
    localparam logic [3:0] B_SQX  = 4'd11;
    localparam logic [3:0] B_SQY  = 4'd12;
    localparam logic [3:0] B_SQRT = 4'd13;
    localparam logic [3:0] B_RND  = 4'd14;
    localparam logic [3:0] B_OUT  = 4'd15;

    logic [3:0]         r_state;
    logic               r_last;
    logic [10:0]        r_c;
    logic               r_sgnx;
    logic               r_sgny;
    logic [32:0]        r_nx;
    logic [32:0]        r_ny;
    logic [10:0]        r_remx;
    logic [10:0]        r_remy;
    logic [32:0]        r_qx;
    logic [32:0]        r_qy;
    logic [5:0]         r_bitn;
    logic signed [33:0] r_mx;
    logic signed [33:0] r_my;
    logic signed [45:0] r_x;
    logic signed [45:0] r_y;
    logic signed [25:0] r_z;
    logic [3:0]         r_it;
    logic [15:0]        r_b;
    logic signed [23:0] r_ox;
    logic signed [23:0] r_oy;
    logic signed [21:0] r_lx;
    logic signed [21:0] r_ly;
    logic [45:0]        r_acc;
    logic [45:0]        r_r;
    logic [45:0]        r_bit;
    logic               r_ovalid;
    logic [21:0]        r_orange;
    logic [15:0]        r_obear;
    logic signed [21:0] r_ox_out;
    logic signed [21:0] r_oy_out;
    logic               r_olast;

    logic [10:0]        c_in;
    logic [32:0]        ax_in;
    logic [32:0]        ay_in;
    logic [11:0]        tx;
    logic [11:0]        ty;
    logic signed [41:0] vx0;
    logic signed [41:0] vy0;
    logic signed [25:0] z0;
    logic signed [45:0] x_sh;
    logic signed [45:0] y_sh;
    logic signed [25:0] tab;
    logic signed [25:0] zr;
    logic signed [23:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [56:0] mul_p;
    logic signed [56:0] rnd24;
    logic [45:0]        rb_sum;
    logic               load;

    assign c_in  = (i_job.count == '0) ? 11'd1 : i_job.count;
    assign ax_in = (i_job.sum_x[31] ? (33'h1_0000_0000 - {1'b0, i_job.sum_x})
                                    : {1'b0, i_job.sum_x}) + 33'(c_in[10:1]);
    assign ay_in = (i_job.sum_y[31] ? (33'h1_0000_0000 - {1'b0, i_job.sum_y})
                                    : {1'b0, i_job.sum_y}) + 33'(c_in[10:1]);
    assign tx    = {r_remx, r_nx[32]};
    assign ty    = {r_remy, r_ny[32]};
    assign vx0   = {r_mx, 8'd0};
    assign vy0   = {r_my, 8'd0};
    assign z0    = {{2{r_b[15]}}, r_b, 8'd0};
    assign x_sh  = r_x >>> r_it;
    assign y_sh  = r_y >>> r_it;
    assign tab   = atan_lut(r_it);
    assign zr    = (r_z + 26'sd128) >>> 8;
    assign rb_sum = r_r + r_bit;
    assign o_job_pop = (r_state == B_IDLE) && !i_job_empty;
    assign load  = (r_state == B_OUT) && (!r_ovalid || o_landmark.ready);

    // Multiplier for the push gain and the squares of the landmark x and y.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            B_GX: begin
                mul_a = INV_GAIN;
                mul_b = r_x[32:0];
            end
            B_GY: begin
                mul_a = INV_GAIN;
                mul_b = r_y[32:0];
            end
            B_SQX: begin
                mul_a = 24'(r_lx);
                mul_b = 33'(r_lx);
            end
            B_SQY: begin
                mul_a = 24'(r_ly);
                mul_b = 33'(r_ly);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign rnd24 = mul_p + (57'sd1 <<< 23);

    // Landmark sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (!i_job_empty) begin
                        r_last  <= i_job.last;
                        r_c     <= c_in;
                        r_sgnx  <= i_job.sum_x[31];
                        r_sgny  <= i_job.sum_y[31];
                        r_nx    <= ax_in;
                        r_ny    <= ay_in;
                        r_remx  <= '0;
                        r_remy  <= '0;
                        r_qx    <= '0;
                        r_qy    <= '0;
                        r_bitn  <= 6'd32;
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    // One quotient bit of each mean per cycle.
                    if (tx >= {1'b0, r_c}) begin
                        r_remx <= 11'(tx - {1'b0, r_c});
                        r_qx   <= {r_qx[31:0], 1'b1};
                    end else begin
                        r_remx <= tx[10:0];
                        r_qx   <= {r_qx[31:0], 1'b0};
                    end
                    if (ty >= {1'b0, r_c}) begin
                        r_remy <= 11'(ty - {1'b0, r_c});
                        r_qy   <= {r_qy[31:0], 1'b1};
                    end else begin
                        r_remy <= ty[10:0];
                        r_qy   <= {r_qy[31:0], 1'b0};
                    end
                    r_nx   <= {r_nx[31:0], 1'b0};
                    r_ny   <= {r_ny[31:0], 1'b0};
                    r_bitn <= r_bitn - 1'b1;
                    if (r_bitn == '0) begin
                        r_state <= B_MEAN;
                    end
                end
                B_MEAN: begin
                    r_mx    <= r_sgnx ? -$signed({1'b0, r_qx}) : $signed({1'b0, r_qx});
                    r_my    <= r_sgny ? -$signed({1'b0, r_qy}) : $signed({1'b0, r_qy});
                    r_state <= B_VPRE;
                end
                B_VPRE: begin
                    r_it <= '0;
                    if (r_mx == '0 && r_my == '0) begin
                        r_b     <= '0;
                        r_state <= B_RPRE;
                    end else begin
                        if (vx0 < 0) begin
                            r_x <= -46'(vx0);
                            r_y <= -46'(vy0);
                            r_z <= HALF_T;
                        end else begin
                            r_x <= 46'(vx0);
                            r_y <= 46'(vy0);
                            r_z <= '0;
                        end
                        r_state <= B_VEC;
                    end
                end
                B_VEC: begin
                    if (!r_y[45] && r_y != '0) begin
                        r_x <= r_x + y_sh;
                        r_y <= r_y - x_sh;
                        r_z <= r_z + tab;
                    end else begin
                        r_x <= r_x - y_sh;
                        r_y <= r_y + x_sh;
                        r_z <= r_z - tab;
                    end
                    r_it <= r_it + 1'b1;
                    if (r_it == 4'd15) begin
                        r_state <= B_BEAR;
                    end
                end
                B_BEAR: begin
                    r_b     <= zr[15:0];
                    r_state <= B_RPRE;
                end
                B_RPRE: begin
                    r_y  <= '0;
                    r_it <= '0;
                    if (z0 > QUARTER_T) begin
                        r_x <= -PUSH_MAG;
                        r_z <= z0 - HALF_T;
                    end else if (z0 < -QUARTER_T) begin
                        r_x <= -PUSH_MAG;
                        r_z <= z0 + HALF_T;
                    end else begin
                        r_x <= PUSH_MAG;
                        r_z <= z0;
                    end
                    r_state <= B_ROT;
                end
                B_ROT: begin
                    if (!r_z[25]) begin
                        r_x <= r_x - y_sh;
                        r_y <= r_y + x_sh;
                        r_z <= r_z - tab;
                    end else begin
                        r_x <= r_x + y_sh;
                        r_y <= r_y - x_sh;
                        r_z <= r_z + tab;
                    end
                    r_it <= r_it + 1'b1;
                    if (r_it == 4'd15) begin
                        r_state <= B_GX;
                    end
                end
                B_GX: begin
                    r_ox    <= rnd24[47:24];
                    r_state <= B_GY;
                end
                B_GY: begin
                    r_oy    <= rnd24[47:24];
                    r_state <= B_LXY;
                end
                B_LXY: begin
                    r_lx    <= sat22(48'(r_mx) + 48'(r_ox));
                    r_ly    <= sat22(48'(r_my) + 48'(r_oy));
                    r_state <= B_SQX;
                end
                B_SQX: begin
                    r_acc   <= mul_p[45:0];
                    r_state <= B_SQY;
                end
                B_SQY: begin
                    r_acc   <= r_acc + mul_p[45:0];
                    r_r     <= '0;
                    r_bit   <= 46'd1 << 42;
                    r_state <= B_SQRT;
                end
                B_SQRT: begin
                    // One root bit per cycle.
                    if (r_acc >= rb_sum) begin
                        r_acc <= r_acc - rb_sum;
                        r_r   <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= B_RND;
                    end
                end
                B_RND: begin
                    if (r_acc > r_r) begin
                        r_r <= r_r + 1'b1;
                    end
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (load) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (o_landmark.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_orange <= r_r[21:0];
            r_obear  <= r_b;
            r_ox_out <= r_lx;
            r_oy_out <= r_ly;
            r_olast  <= r_last;
        end
    end

    assign o_landmark.valid            = r_ovalid;
    assign o_landmark.landmark_range   = r_orange;
    assign o_landmark.landmark_bearing = r_obear;
    assign o_landmark.landmark_x       = r_ox_out;
    assign o_landmark.landmark_y       = r_oy_out;
    assign o_landmark.scan_last        = r_olast;
endmodule

FILE: rtl/laser_scan_landmark_clusterer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_scan_landmark_clusterer
// Groups the beams of a laser scan into clusters and reports one landmark
// (range, bearing, position) per cluster.
// ----------------------------------------------------------------------------
// Channels: i_beam takes one beam per transfer, o_landmark gives one landmark
// per transfer, i_cfg writes one register per transfer (always ready; write
// only while the block is idle).
// Flow: a dropped beam skips the arithmetic, a kept beam goes through the
// 16-step sine/cosine unit and the shared multiplier of the front. In the
// back, a closed cluster goes through a divider, two 16-step CORDIC passes
// and a square root. A queue of closed clusters lets the front keep taking
// beams meanwhile; a beam that breaks a cluster or ends the scan with one
// open waits while that queue is full.
// Reset clears the registers to their defaults, the beam index and the open
// cluster; no clearing pass is needed.
// When the receiver stalls, the result waits in the output register, the
// back computes one more landmark, then the queue fills and the front holds.
// ----------------------------------------------------------------------------
module laser_scan_landmark_clusterer import lslc_pkg::*; #(
    parameter int MAX_BEAMS   = MAX_BEAMS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lslc_beam_if.sink   i_beam,
    lslc_cfg_if.sink    i_cfg,
    lslc_lmk_if.source  o_landmark
);
    t_cfg r_cfg;
    t_job front_job;
    logic front_push;
    logic q_full;
    t_job q_job;
    logic q_empty;
    logic back_pop;

    assign i_cfg.ready = 1'b1;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_range   <= 20'd0;
            r_cfg.max_range   <= 20'd122880;
            r_cfg.angle_start <= -16'sd32768;
            r_cfg.angle_step  <= 16'sd182;
            r_cfg.mount_cos   <= 16'sd16384;
            r_cfg.mount_sin   <= 16'sd0;
            r_cfg.mount_x     <= 22'sd0;
            r_cfg.mount_y     <= 22'sd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_RANGE_MIN:   r_cfg.min_range   <= i_cfg.data[19:0];
                REG_RANGE_MAX:   r_cfg.max_range   <= i_cfg.data[19:0];
                REG_ANGLE_START: r_cfg.angle_start <= i_cfg.data[15:0];
                REG_ANGLE_STEP:  r_cfg.angle_step  <= i_cfg.data[15:0];
                REG_MOUNT_COS:   r_cfg.mount_cos   <= i_cfg.data[15:0];
                REG_MOUNT_SIN:   r_cfg.mount_sin   <= i_cfg.data[15:0];
                REG_MOUNT_X:     r_cfg.mount_x     <= i_cfg.data;
                REG_MOUNT_Y:     r_cfg.mount_y     <= i_cfg.data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    lslc_front #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beam      (i_beam),
        .i_cfg       (r_cfg),
        .o_job       (front_job),
        .o_job_valid (front_push),
        .i_job_full  (q_full)
    );

    lslc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    lslc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_job_empty (q_empty),
        .o_job_pop   (back_pop),
        .o_landmark  (o_landmark)
    );
endmodule
